[rtl/core/fanout_degree_statistics_core_assert.svh]
// Assertion macros shared by the fanout statistics checker.
// Depends on signals named clock and reset in the including scope.
`ifndef FANOUT_DEGREE_STATISTICS_CORE_ASSERT_SVH
`define FANOUT_DEGREE_STATISTICS_CORE_ASSERT_SVH

// Same-cycle implication, inactive during reset.
`define FDSC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, inactive during reset.
`define FDSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also covers reset itself.
`define FDSC_ASSERT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/fdsc_pkg.sv]
// Package for the fanout statistics core: sizes, codes and the
// command/status structs between controller and datapath. No dependencies.
package fdsc_pkg;

   localparam int MAX_ELEMENTS = 4096;
   localparam int DEGREE_BITS  = 16;

   localparam int ADDR_W  = $clog2(MAX_ELEMENTS);
   localparam int CNT_W   = ADDR_W + 1;
   localparam int FO_W    = (DEGREE_BITS < 16) ? DEGREE_BITS : 16;
   localparam int SUM_W   = FO_W + CNT_W;
   localparam int SQ_W    = (2 * FO_W + CNT_W > 64) ? 64 : 2 * FO_W + CNT_W;
   localparam int ACC_W   = 64;
   localparam int ROOT_W  = 32;
   localparam int DVS_W   = 2 * CNT_W;
   localparam int DVD_W   = ACC_W + 32;
   localparam int DIVC_W  = $clog2(DVD_W);
   localparam int THR_W   = 16;
   localparam int VAL_W   = 48;
   localparam int IDX_W   = 5;
   localparam int KIND_W  = 2;
   localparam int PORT_W  = 16;
   localparam int ENTRY_W = KIND_W + FO_W;

   localparam logic [THR_W-1:0] FIXED_DEFAULT = 16'd10;

   localparam logic [KIND_W-1:0] KIND_COMB  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SEQ   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PI    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLOCK = 2'd3;

   // statistic groups: three kinds, overall, combinational fanin
   localparam logic [2:0] GRP_COMB    = 3'd0;
   localparam logic [2:0] GRP_SEQ     = 3'd1;
   localparam logic [2:0] GRP_PI      = 3'd2;
   localparam logic [2:0] GRP_OVERALL = 3'd3;
   localparam logic [2:0] GRP_FANIN   = 3'd4;
   localparam int         N_GROUPS    = 5;

   localparam logic [IDX_W-1:0] STAT_MAX   = 5'd0;
   localparam logic [IDX_W-1:0] STAT_AVG0  = 5'd1;
   localparam logic [IDX_W-1:0] STAT_AVGN  = 5'd5;
   localparam logic [IDX_W-1:0] STAT_DEV0  = 5'd6;
   localparam logic [IDX_W-1:0] STAT_DEVN  = 5'd10;
   localparam logic [IDX_W-1:0] STAT_HIGH0 = 5'd11;
   localparam logic [IDX_W-1:0] STAT_LAST  = 5'd16;

   localparam logic [3:0] MUL_LAST = 4'd8;

   typedef struct packed {
      logic             acc;
      logic             clr;
      logic             load;
      logic [2:0]       grp;
      logic             div_avg;
      logic             div_dev;
      logic             sqrt_go;
      logic             store_avg;
      logic             store_dev;
      logic             zero_avg;
      logic             zero_dev;
      logic             mul_go;
      logic [3:0]       mul_step;
      logic             scan_start;
      logic             scan_rd;
      logic             emit;
      logic [IDX_W-1:0] emit_idx;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic a_lt_b;
      logic div_done;
      logic sqrt_done;
      logic scan_end;
      logic out_free;
   } status_type;

endpackage

[rtl/core/fdsc_div.sv]
// Restoring divider, one quotient bit per cycle, low quotient bits kept.
// Depends on fdsc_pkg.
module fdsc_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [fdsc_pkg::DVD_W-1:0]   dividend,
   input  logic [fdsc_pkg::DVS_W-1:0]   divisor,
   output logic                         done,
   output logic [fdsc_pkg::ACC_W-1:0]   quotient
);
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [fdsc_pkg::DIVC_W-1:0]   cnt_ff, cnt_in;
   logic [fdsc_pkg::DVD_W-1:0]    dvd_ff, dvd_in;
   logic [fdsc_pkg::DVS_W-1:0]    dvs_ff, dvs_in;
   logic [fdsc_pkg::DVS_W-1:0]    rem_ff, rem_in;
   logic [fdsc_pkg::ACC_W-1:0]    quo_ff, quo_in;
   logic [fdsc_pkg::DVS_W:0]      trial, diff;
   logic                          ge;

   assign trial = {rem_ff, dvd_ff[fdsc_pkg::DVD_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[fdsc_pkg::DVS_W-1:0] : trial[fdsc_pkg::DVS_W-1:0];
         quo_in = {quo_ff[fdsc_pkg::ACC_W-2:0], ge};
         dvd_in = {dvd_ff[fdsc_pkg::DVD_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == fdsc_pkg::DIVC_W'(fdsc_pkg::DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

[rtl/core/fdsc_sqrt.sv]
// Integer square root, one result bit per cycle, truncated toward zero.
// Depends on fdsc_pkg.
module fdsc_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fdsc_pkg::ACC_W-1:0]    radicand,
   output logic                          done,
   output logic [fdsc_pkg::ROOT_W-1:0]   root
);
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [fdsc_pkg::ACC_W-1:0]    x_ff, x_in;
   logic [fdsc_pkg::ACC_W-1:0]    res_ff, res_in;
   logic [fdsc_pkg::ACC_W-1:0]    bit_ff, bit_in;
   logic [fdsc_pkg::ACC_W-1:0]    trial;

   assign trial = res_ff + bit_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         x_in    = radicand;
         res_in  = '0;
         bit_in  = {2'b01, {(fdsc_pkg::ACC_W-2){1'b0}}};
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in   = x_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[fdsc_pkg::ROOT_W-1:0];
endmodule

[rtl/core/fdsc_dp.sv]
// Datapath: accumulators, element store, shared multiplier, divider, root
// unit, threshold scan and result register. Depends on fdsc_pkg, fdsc_div, fdsc_sqrt.
module fdsc_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  fdsc_pkg::cmd_type                cmd,
   output fdsc_pkg::status_type             sts,
   input  logic [fdsc_pkg::KIND_W-1:0]      req_element_kind,
   input  logic [fdsc_pkg::PORT_W-1:0]      req_fanout_degree,
   input  logic [fdsc_pkg::PORT_W-1:0]      req_fanin_degree,
   input  logic                             csr_valid,
   input  logic [fdsc_pkg::THR_W-1:0]       csr_fixed_threshold,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [fdsc_pkg::IDX_W-1:0]       rsp_stat_index,
   output logic [fdsc_pkg::VAL_W-1:0]       rsp_stat_value,
   output logic                             rsp_last_of_run
);
   localparam int FO_W     = fdsc_pkg::FO_W;
   localparam int ACC_W    = fdsc_pkg::ACC_W;
   localparam int CNT_W    = fdsc_pkg::CNT_W;
   localparam int KIND_W_L = fdsc_pkg::KIND_W;

   logic [fdsc_pkg::THR_W-1:0]   thr_ff;
   logic [CNT_W-1:0]             count_ff;
   logic [CNT_W-1:0]             kcnt_ff [3];
   logic [fdsc_pkg::SUM_W-1:0]   dsum_ff [4];
   logic [fdsc_pkg::SQ_W-1:0]    sqsum_ff [4];
   logic [FO_W-1:0]              largest_ff;
   logic [CNT_W-1:0]             high_ff [6];

   logic [fdsc_pkg::ENTRY_W-1:0] mem [fdsc_pkg::MAX_ELEMENTS];
   logic [fdsc_pkg::ENTRY_W-1:0] mem_q_ff;
   logic                         rd_vld_ff;
   logic [CNT_W-1:0]             scan_addr_ff;
   logic [ACC_W-1:0]             cut_ff;

   logic [CNT_W-1:0]             n_ff;
   logic [ACC_W-1:0]             s_ff, q_ff;
   logic [ACC_W-1:0]             a_ff, b_ff, m_ff;
   logic [ACC_W-1:0]             prod_ff;
   logic [1:0]                   prod_p_ff, prod_j_ff;
   logic                         prod_vld_ff;
   logic [ACC_W-1:0]             avg_ff [fdsc_pkg::N_GROUPS];
   logic [fdsc_pkg::ROOT_W-1:0]  dev_ff [fdsc_pkg::N_GROUPS];

   logic                         rsp_valid_ff;
   logic [fdsc_pkg::IDX_W-1:0]   rsp_idx_ff;
   logic [fdsc_pkg::VAL_W-1:0]   rsp_val_ff;
   logic                         rsp_last_ff;

   logic [FO_W-1:0]              fo, fi;
   logic [2*FO_W-1:0]            fo_sq, fi_sq;
   logic                         take;
   logic [CNT_W-1:0]             n_sel;
   logic [ACC_W-1:0]             s_sel, q_sel;
   logic [1:0]                   mp, mj;
   logic [ACC_W-1:0]             xop, yop;
   logic [31:0]                  xpart, ypart;
   logic [fdsc_pkg::DVD_W-1:0]   dividend;
   logic [fdsc_pkg::DVS_W-1:0]   divisor;
   logic                         div_done, sqrt_done;
   logic [ACC_W-1:0]             quotient;
   logic [fdsc_pkg::ROOT_W-1:0]  root;
   logic [ACC_W-1:0]             stat_val;
   logic [KIND_W_L-1:0]          scan_kind;
   logic [FO_W-1:0]              scan_fo;
   logic [ACC_W-1:0]             scan_fo_q16;
   logic [fdsc_pkg::IDX_W-1:0]   rel;

   assign fo    = req_fanout_degree[FO_W-1:0];
   assign fi    = req_fanin_degree[FO_W-1:0];
   assign fo_sq = fo * fo;
   assign fi_sq = fi * fi;
   assign take  = cmd.acc && (req_element_kind != fdsc_pkg::KIND_CLOCK)
                  && (count_ff < CNT_W'(fdsc_pkg::MAX_ELEMENTS));

   // group operand selection
   always_comb begin
      n_sel = kcnt_ff[0];
      s_sel = ACC_W'(dsum_ff[0]);
      q_sel = ACC_W'(sqsum_ff[0]);
      case (cmd.grp)
         fdsc_pkg::GRP_COMB: begin
            n_sel = kcnt_ff[0];
            s_sel = ACC_W'(dsum_ff[0]);
            q_sel = ACC_W'(sqsum_ff[0]);
         end
         fdsc_pkg::GRP_SEQ: begin
            n_sel = kcnt_ff[1];
            s_sel = ACC_W'(dsum_ff[1]);
            q_sel = ACC_W'(sqsum_ff[1]);
         end
         fdsc_pkg::GRP_PI: begin
            n_sel = kcnt_ff[2];
            s_sel = ACC_W'(dsum_ff[2]);
            q_sel = ACC_W'(sqsum_ff[2]);
         end
         fdsc_pkg::GRP_OVERALL: begin
            n_sel = kcnt_ff[0] + kcnt_ff[1] + kcnt_ff[2];
            s_sel = ACC_W'(dsum_ff[0]) + ACC_W'(dsum_ff[1]) + ACC_W'(dsum_ff[2]);
            q_sel = ACC_W'(sqsum_ff[0]) + ACC_W'(sqsum_ff[1]) + ACC_W'(sqsum_ff[2]);
         end
         fdsc_pkg::GRP_FANIN: begin
            n_sel = kcnt_ff[0];
            s_sel = ACC_W'(dsum_ff[3]);
            q_sel = ACC_W'(sqsum_ff[3]);
         end
         default: begin
            n_sel = kcnt_ff[0];
         end
      endcase
   end

   // multiplier schedule: product p (n*q, s*s, n*n), partial j (ll, lh, hl)
   always_comb begin
      case (cmd.mul_step)
         4'd0: begin mp = 2'd0; mj = 2'd0; end
         4'd1: begin mp = 2'd0; mj = 2'd1; end
         4'd2: begin mp = 2'd0; mj = 2'd2; end
         4'd3: begin mp = 2'd1; mj = 2'd0; end
         4'd4: begin mp = 2'd1; mj = 2'd1; end
         4'd5: begin mp = 2'd1; mj = 2'd2; end
         4'd6: begin mp = 2'd2; mj = 2'd0; end
         4'd7: begin mp = 2'd2; mj = 2'd1; end
         4'd8: begin mp = 2'd2; mj = 2'd2; end
         default: begin mp = 2'd0; mj = 2'd0; end
      endcase
      case (mp)
         2'd0:    begin xop = ACC_W'(n_ff); yop = q_ff; end
         2'd1:    begin xop = s_ff;         yop = s_ff; end
         default: begin xop = ACC_W'(n_ff); yop = ACC_W'(n_ff); end
      endcase
      case (mj)
         2'd0:    begin xpart = xop[31:0];  ypart = yop[31:0];  end
         2'd1:    begin xpart = xop[31:0];  ypart = yop[63:32]; end
         default: begin xpart = xop[63:32]; ypart = yop[31:0];  end
      endcase
   end

   assign dividend = cmd.div_dev ? {a_ff - b_ff, 32'd0} : {32'd0, s_ff << 16};
   assign divisor  = cmd.div_dev ? m_ff[fdsc_pkg::DVS_W-1:0]
                                 : fdsc_pkg::DVS_W'(n_ff);

   fdsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_avg | cmd.div_dev),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   fdsc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_go),
      .radicand (quotient),
      .done     (sqrt_done),
      .root     (root)
   );

   assign scan_kind   = mem_q_ff[fdsc_pkg::ENTRY_W-1 -: KIND_W_L];
   assign scan_fo     = mem_q_ff[FO_W-1:0];
   assign scan_fo_q16 = ACC_W'({scan_fo, 16'd0});

   // statistic selection for the result register
   always_comb begin
      rel = '0;
      case (cmd.emit_idx) inside
         fdsc_pkg::STAT_MAX: begin
            stat_val = ACC_W'({largest_ff, 16'd0});
         end
         [fdsc_pkg::STAT_AVG0:fdsc_pkg::STAT_AVGN]: begin
            rel      = cmd.emit_idx - fdsc_pkg::STAT_AVG0;
            stat_val = avg_ff[rel[2:0]];
         end
         [fdsc_pkg::STAT_DEV0:fdsc_pkg::STAT_DEVN]: begin
            rel      = cmd.emit_idx - fdsc_pkg::STAT_DEV0;
            stat_val = ACC_W'(dev_ff[rel[2:0]]);
         end
         [fdsc_pkg::STAT_HIGH0:fdsc_pkg::STAT_LAST]: begin
            rel      = cmd.emit_idx - fdsc_pkg::STAT_HIGH0;
            stat_val = ACC_W'({high_ff[rel[2:0]], 16'd0});
         end
         default: begin
            stat_val = '0;
         end
      endcase
   end

   // element store
   always_ff @(posedge clock) begin
      if (take) begin
         mem[count_ff[fdsc_pkg::ADDR_W-1:0]] <= {req_element_kind, fo};
      end
      if (cmd.scan_rd) begin
         mem_q_ff <= mem[scan_addr_ff[fdsc_pkg::ADDR_W-1:0]];
      end
   end

   // accumulators and high counts
   always_ff @(posedge clock) begin
      if (reset || cmd.clr) begin
         count_ff   <= '0;
         largest_ff <= '0;
         for (int k = 0; k < 3; k++) kcnt_ff[k] <= '0;
         for (int k = 0; k < 4; k++) begin
            dsum_ff[k]  <= '0;
            sqsum_ff[k] <= '0;
         end
         for (int k = 0; k < 6; k++) high_ff[k] <= '0;
      end else begin
         if (take) begin
            count_ff <= count_ff + 1'b1;
            kcnt_ff[req_element_kind]  <= kcnt_ff[req_element_kind] + 1'b1;
            dsum_ff[req_element_kind]  <= dsum_ff[req_element_kind]
                                          + fdsc_pkg::SUM_W'(fo);
            sqsum_ff[req_element_kind] <= sqsum_ff[req_element_kind]
                                          + fdsc_pkg::SQ_W'(fo_sq);
            if (req_element_kind == fdsc_pkg::KIND_COMB) begin
               dsum_ff[3]  <= dsum_ff[3] + fdsc_pkg::SUM_W'(fi);
               sqsum_ff[3] <= sqsum_ff[3] + fdsc_pkg::SQ_W'(fi_sq);
            end
            if (fo > largest_ff) largest_ff <= fo;
         end
         if (rd_vld_ff && scan_kind != fdsc_pkg::KIND_CLOCK) begin
            if (fdsc_pkg::THR_W'(scan_fo) >= thr_ff) begin
               high_ff[scan_kind] <= high_ff[scan_kind] + 1'b1;
            end
            if (scan_fo_q16 >= cut_ff) begin
               high_ff[3'd3 + {1'b0, scan_kind}] <= high_ff[3'd3 + {1'b0, scan_kind}]
                                                   + 1'b1;
            end
         end
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= fdsc_pkg::FIXED_DEFAULT;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) thr_ff <= csr_fixed_threshold;
         rd_vld_ff   <= cmd.scan_rd;
         prod_vld_ff <= cmd.mul_go;
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // compute payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff <= n_sel;
         s_ff <= s_sel;
         q_ff <= q_sel;
      end
      if (cmd.mul_go) begin
         prod_ff   <= xpart * ypart;
         prod_p_ff <= mp;
         prod_j_ff <= mj;
      end
      if (prod_vld_ff) begin
         case (prod_p_ff)
            2'd0:    a_ff <= (prod_j_ff == 2'd0) ? prod_ff : a_ff + (prod_ff << 32);
            2'd1:    b_ff <= (prod_j_ff == 2'd0) ? prod_ff : b_ff + (prod_ff << 32);
            default: m_ff <= (prod_j_ff == 2'd0) ? prod_ff : m_ff + (prod_ff << 32);
         endcase
      end
      if (cmd.store_avg) avg_ff[cmd.grp] <= quotient;
      if (cmd.zero_avg)  avg_ff[cmd.grp] <= '0;
      if (cmd.store_dev) dev_ff[cmd.grp] <= root;
      if (cmd.zero_dev)  dev_ff[cmd.grp] <= '0;
      if (cmd.scan_start) begin
         scan_addr_ff <= '0;
         cut_ff       <= avg_ff[fdsc_pkg::GRP_OVERALL]
                         + ACC_W'(dev_ff[fdsc_pkg::GRP_OVERALL]);
      end else if (cmd.scan_rd) begin
         scan_addr_ff <= scan_addr_ff + 1'b1;
      end
      if (cmd.emit) begin
         rsp_idx_ff  <= cmd.emit_idx;
         rsp_val_ff  <= stat_val[fdsc_pkg::VAL_W-1:0];
         rsp_last_ff <= (cmd.emit_idx == fdsc_pkg::STAT_LAST);
      end
   end

   assign sts.n_zero    = (n_ff == '0);
   assign sts.a_lt_b    = (a_ff < b_ff);
   assign sts.div_done  = div_done;
   assign sts.sqrt_done = sqrt_done;
   assign sts.scan_end  = (scan_addr_ff == count_ff);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_stat_index  = rsp_idx_ff;
   assign rsp_stat_value  = rsp_val_ff;
   assign rsp_last_of_run = rsp_last_ff;
endmodule

[rtl/core/fdsc_ctrl.sv]
// Controller state machine: sequences loading, per-group statistics,
// the threshold scan and emission. Depends on fdsc_pkg.
module fdsc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last_element,
   input  fdsc_pkg::status_type    sts,
   output logic                    req_ready,
   output fdsc_pkg::cmd_type       cmd
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_CHECK, ST_AVG_WAIT, ST_MUL, ST_MUL_DRAIN,
      ST_DEV_CHECK, ST_DEV_WAIT, ST_SQ_WAIT, ST_NEXT, ST_SCAN_INIT,
      ST_SCAN, ST_SCAN_DRAIN, ST_EMIT
   } state_type;

   state_type                    state_ff, state_in;
   logic [2:0]                   grp_ff, grp_in;
   logic [3:0]                   mstep_ff, mstep_in;
   logic [fdsc_pkg::IDX_W-1:0]   idx_ff, idx_in;

   always_comb begin
      state_in     = state_ff;
      grp_in       = grp_ff;
      mstep_in     = mstep_ff;
      idx_in       = idx_ff;
      cmd          = '0;
      cmd.grp      = grp_ff;
      cmd.mul_step = mstep_ff;
      cmd.emit_idx = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.acc = 1'b1;
               if (req_last_element) begin
                  grp_in   = fdsc_pkg::GRP_COMB;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.n_zero) begin
               cmd.zero_avg = 1'b1;
               cmd.zero_dev = 1'b1;
               state_in     = ST_NEXT;
            end else begin
               cmd.div_avg = 1'b1;
               state_in    = ST_AVG_WAIT;
            end
         end
         ST_AVG_WAIT: begin
            if (sts.div_done) begin
               cmd.store_avg = 1'b1;
               mstep_in      = '0;
               state_in      = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_go = 1'b1;
            mstep_in   = mstep_ff + 1'b1;
            if (mstep_ff == fdsc_pkg::MUL_LAST) state_in = ST_MUL_DRAIN;
         end
         ST_MUL_DRAIN: begin
            state_in = ST_DEV_CHECK;
         end
         ST_DEV_CHECK: begin
            if (sts.a_lt_b) begin
               cmd.zero_dev = 1'b1;
               state_in     = ST_NEXT;
            end else begin
               cmd.div_dev = 1'b1;
               state_in    = ST_DEV_WAIT;
            end
         end
         ST_DEV_WAIT: begin
            if (sts.div_done) begin
               cmd.sqrt_go = 1'b1;
               state_in    = ST_SQ_WAIT;
            end
         end
         ST_SQ_WAIT: begin
            if (sts.sqrt_done) begin
               cmd.store_dev = 1'b1;
               state_in      = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (grp_ff == fdsc_pkg::GRP_FANIN) begin
               state_in = ST_SCAN_INIT;
            end else begin
               grp_in   = grp_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_SCAN_INIT: begin
            cmd.scan_start = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.scan_end) state_in = ST_SCAN_DRAIN;
            else cmd.scan_rd = 1'b1;
         end
         ST_SCAN_DRAIN: begin
            idx_in   = fdsc_pkg::STAT_MAX;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               idx_in   = idx_ff + 1'b1;
               if (idx_ff == fdsc_pkg::STAT_LAST) begin
                  cmd.clr  = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         grp_ff   <= '0;
         mstep_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         grp_ff   <= grp_in;
         mstep_ff <= mstep_in;
         idx_ff   <= idx_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
endmodule

[rtl/core/fanout_degree_statistics_core.sv]
// Top level of the fanout statistics core: controller plus datapath.
// Depends on fdsc_pkg, fdsc_ctrl and fdsc_dp.
//
// Netlist elements stream in one transaction per cycle (kind, fanout, fanin,
// last flag); clock-port elements are skipped and at most 4096 elements are
// kept per data set. The transaction flagged last closes the set: the core
// then stops taking input and works out, for five groups (combinational,
// sequential, primary input, overall fanout, combinational fanin), the Q16
// average with one shared 96-step restoring divider, the variance terms with
// one shared 32x32 multiplier, a second 96-step division and a 32-step
// integer root. A scan over the stored elements, one per cycle, then builds
// the threshold counts, and 17 result transactions leave through a registered
// output, one per cycle when the sink is ready. The compute time is set by
// the divider and root iterations and the single store read port. The
// threshold register may be written at any idle time.
module fanout_degree_statistics_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [fdsc_pkg::KIND_W-1:0]       req_element_kind,
   input  logic [fdsc_pkg::PORT_W-1:0]       req_fanout_degree,
   input  logic [fdsc_pkg::PORT_W-1:0]       req_fanin_degree,
   input  logic                              req_last_element,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fdsc_pkg::IDX_W-1:0]        rsp_stat_index,
   output logic [fdsc_pkg::VAL_W-1:0]        rsp_stat_value,
   output logic                              rsp_last_of_run,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fdsc_pkg::THR_W-1:0]        csr_fixed_threshold
);
   fdsc_pkg::cmd_type    cmd;
   fdsc_pkg::status_type sts;

   // the threshold register takes a write in any cycle
   assign csr_ready = 1'b1;

   fdsc_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_last_element (req_last_element),
      .sts              (sts),
      .req_ready        (req_ready),
      .cmd              (cmd)
   );

   fdsc_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_element_kind    (req_element_kind),
      .req_fanout_degree   (req_fanout_degree),
      .req_fanin_degree    (req_fanin_degree),
      .csr_valid           (csr_valid),
      .csr_fixed_threshold (csr_fixed_threshold),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_stat_index      (rsp_stat_index),
      .rsp_stat_value      (rsp_stat_value),
      .rsp_last_of_run     (rsp_last_of_run)
   );
endmodule

[rtl/core/fdsc_checker.sv]
// Port-level checker for the fanout statistics core, bound to the top level.
// Depends on fdsc_pkg and fanout_degree_statistics_core_assert.svh.
`include "fanout_degree_statistics_core_assert.svh"

module fdsc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_last_element,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [fdsc_pkg::IDX_W-1:0]     rsp_stat_index,
   input logic [fdsc_pkg::VAL_W-1:0]     rsp_stat_value,
   input logic                           rsp_last_of_run
);
   `FDSC_ASSERT_RST(a_reset_idle, reset, !rsp_valid, "result valid after reset")
   `FDSC_ASSERT_NOW(a_last_flag, rsp_valid, rsp_last_of_run == (rsp_stat_index == fdsc_pkg::STAT_LAST), "last flag off final index")
   `FDSC_ASSERT_NEXT(a_close_stall, req_valid && req_ready && req_last_element, !req_ready, "input taken after closing transaction")
   `FDSC_ASSERT_NEXT(a_run_stall, rsp_valid && rsp_ready && rsp_stat_index < (fdsc_pkg::STAT_LAST - 5'd1), !req_ready, "input taken mid run")
   `FDSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_stat_value), "stalled result changed")
endmodule

bind fanout_degree_statistics_core fdsc_checker u_fdsc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_last_element (req_last_element),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_stat_index   (rsp_stat_index),
   .rsp_stat_value   (rsp_stat_value),
   .rsp_last_of_run  (rsp_last_of_run)
);

[bench/fanout_degree_statistics_checker.sv]
// Checker for the fanout statistics core: watches all three channels, predicts the
// 17-entry statistics run per data set and compares it. Depends on fdsc_pkg.
module fanout_degree_statistics_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [fdsc_pkg::KIND_W-1:0]  req_element_kind,
   input  logic [fdsc_pkg::PORT_W-1:0]  req_fanout_degree,
   input  logic [fdsc_pkg::PORT_W-1:0]  req_fanin_degree,
   input  logic                         req_last_element,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [fdsc_pkg::IDX_W-1:0]   rsp_stat_index,
   input  logic [fdsc_pkg::VAL_W-1:0]   rsp_stat_value,
   input  logic                         rsp_last_of_run,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [fdsc_pkg::THR_W-1:0]   csr_fixed_threshold,
   output int                           failures,
   output int                           stats_pending,
   output int                           stats_seen
);

   typedef struct {
      logic [fdsc_pkg::IDX_W-1:0] index;
      logic [fdsc_pkg::VAL_W-1:0] value;
      logic                       last;
   } stat_type;

   stat_type                   expected_stats[$];
   logic [fdsc_pkg::THR_W-1:0] threshold;
   logic [1:0]                 kept_kind[fdsc_pkg::MAX_ELEMENTS];
   longint unsigned            kept_fanout[fdsc_pkg::MAX_ELEMENTS];
   int                         kept_count;
   longint unsigned            kind_total[3];
   longint unsigned            sum_deg[4];
   longint unsigned            sum_sq[4];
   longint unsigned            peak_fanout;

   function automatic longint unsigned int_root(longint unsigned x);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned mean_q16(longint unsigned s, longint unsigned n);
      return (n == 0) ? 64'd0 : (s << 16) / n;
   endfunction

   function automatic longint unsigned spread_q16(longint unsigned s, longint unsigned sq,
                                                  longint unsigned n);
      longint unsigned a, b, m, q, r;
      if (n == 0) return 0;
      a = n * sq;
      b = s * s;
      if (a < b) return 0;
      m = n * n;
      if (m == 0) return 0;
      q = (a - b) / m;
      r = (a - b) % m;
      for (int i = 0; i < 32; i++) begin
         r <<= 1;
         q <<= 1;
         if (r >= m) begin
            r = r - m;
            q |= 64'd1;
         end
      end
      return int_root(q);
   endfunction

   task automatic clear_set();
      kept_count  = 0;
      peak_fanout = 0;
      for (int k = 0; k < 4; k++) begin
         sum_deg[k] = 0;
         sum_sq[k]  = 0;
         if (k < 3) kind_total[k] = 0;
      end
   endtask

   // Fold one element in; on the last flag push the whole statistics run.
   task automatic absorb_element(logic [1:0] kind, longint unsigned fo, longint unsigned fi,
                                 logic last);
      longint unsigned st[17];
      longint unsigned n_all, s_all, q_all, cut;
      longint unsigned high[6];
      stat_type        e;
      if (kind != fdsc_pkg::KIND_CLOCK && kept_count < fdsc_pkg::MAX_ELEMENTS) begin
         kept_kind[kept_count]   = kind;
         kept_fanout[kept_count] = fo;
         kept_count++;
         kind_total[kind]++;
         sum_deg[kind] += fo;
         sum_sq[kind]  += fo * fo;
         if (kind == fdsc_pkg::KIND_COMB) begin
            sum_deg[3] += fi;
            sum_sq[3]  += fi * fi;
         end
         if (fo > peak_fanout) peak_fanout = fo;
      end
      if (!last) return;
      n_all = kind_total[0] + kind_total[1] + kind_total[2];
      s_all = sum_deg[0] + sum_deg[1] + sum_deg[2];
      q_all = sum_sq[0] + sum_sq[1] + sum_sq[2];
      st[0] = peak_fanout << 16;
      for (int k = 0; k < 3; k++) begin
         st[1 + k] = mean_q16(sum_deg[k], kind_total[k]);
         st[6 + k] = spread_q16(sum_deg[k], sum_sq[k], kind_total[k]);
      end
      st[4]  = mean_q16(s_all, n_all);
      st[9]  = spread_q16(s_all, q_all, n_all);
      st[5]  = mean_q16(sum_deg[3], kind_total[0]);
      st[10] = spread_q16(sum_deg[3], sum_sq[3], kind_total[0]);
      cut = st[4] + st[9];
      for (int k = 0; k < 6; k++) high[k] = 0;
      for (int i = 0; i < kept_count; i++) begin
         if (kept_fanout[i] >= threshold) high[kept_kind[i]]++;
         if ((kept_fanout[i] << 16) >= cut) high[3 + kept_kind[i]]++;
      end
      for (int k = 0; k < 6; k++) st[11 + k] = high[k] << 16;
      for (int k = 0; k < 17; k++) begin
         e.index = fdsc_pkg::IDX_W'(k);
         e.value = st[k][fdsc_pkg::VAL_W-1:0];
         e.last  = (e.index == fdsc_pkg::STAT_LAST);
         expected_stats.push_back(e);
      end
      clear_set();
   endtask

   always @(posedge clock) begin
      stat_type e;
      if (reset) begin
         expected_stats.delete();
         threshold = fdsc_pkg::FIXED_DEFAULT;
         clear_set();
         failures   = 0;
         stats_seen = 0;
      end else begin
         if (csr_valid && csr_ready) threshold = csr_fixed_threshold;
         if (req_valid && req_ready)
            absorb_element(req_element_kind, 64'(req_fanout_degree),
                           64'(req_fanin_degree), req_last_element);
         if (rsp_valid && rsp_ready) begin
            stats_seen++;
            if (expected_stats.size() == 0) begin
               failures++;
               $display("%0t: unexpected statistic index %0d value %h", $time,
                        rsp_stat_index, rsp_stat_value);
            end else begin
               e = expected_stats.pop_front();
               if (rsp_stat_index !== e.index) begin
                  failures++;
                  $display("%0t: stat_index expected %0d actual %0d", $time, e.index,
                           rsp_stat_index);
               end
               if (rsp_stat_value !== e.value) begin
                  failures++;
                  $display("%0t: stat_value (index %0d) expected %h actual %h", $time,
                           e.index, e.value, rsp_stat_value);
               end
               if (rsp_last_of_run !== e.last) begin
                  failures++;
                  $display("%0t: last_of_run (index %0d) expected %0b actual %0b", $time,
                           e.index, e.last, rsp_last_of_run);
               end
            end
         end
      end
      stats_pending = expected_stats.size();
   end

endmodule

[bench/tb_fanout_degree_statistics_core.sv]
// Testbench top for the fanout statistics core: clock, reset, stimulus and verdict.
// Depends on fdsc_pkg, fanout_degree_statistics_core and fanout_degree_statistics_checker.
module tb_fanout_degree_statistics_core;

   localparam int CYCLE_LIMIT = 3000000;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic [fdsc_pkg::KIND_W-1:0]  req_element_kind;
   logic [fdsc_pkg::PORT_W-1:0]  req_fanout_degree;
   logic [fdsc_pkg::PORT_W-1:0]  req_fanin_degree;
   logic                         req_last_element;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic [fdsc_pkg::IDX_W-1:0]   rsp_stat_index;
   logic [fdsc_pkg::VAL_W-1:0]   rsp_stat_value;
   logic                         rsp_last_of_run;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [fdsc_pkg::THR_W-1:0]   csr_fixed_threshold;

   int failures, stats_pending, stats_seen;
   int cycle_count;
   int elements_sent;
   int sets_sent;
   bit gaps_off;       // switch for back-to-back traffic on both sides, toggled between sets
   int sink_hold;      // one-shot long hold-off for the result side

   fanout_degree_statistics_core dut (.*);

   fanout_degree_statistics_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Bail out on a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Result side: random stalls per transaction, plus one long hold-off on request.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (sink_hold > 0) begin
            stall     = sink_hold;
            sink_hold = 0;
         end else begin
            stall = gaps_off ? 0 : $urandom_range(0, 12);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Offer one element; hold valid and payload until the transaction is taken.
   task automatic send_element(logic [1:0] kind, logic [15:0] fo, logic [15:0] fi,
                               logic last);
      int gap;
      gap = gaps_off ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_element_kind  <= kind;
      req_fanout_degree <= fo;
      req_fanin_degree  <= fi;
      req_last_element  <= last;
      do @(posedge clock); while (!req_ready);
      elements_sent++;
      if (last) sets_sent++;
   endtask

   // Drain outstanding results, let the core settle, then write the register.
   task automatic write_threshold(logic [15:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (stats_pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      csr_valid           <= 1'b1;
      csr_fixed_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] draw_fanout();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) return 16'($urandom_range(0, 30));
      if (pick < 9) return 16'($urandom_range(0, 65535));
      return 16'hFFFF;
   endfunction

   // Random data sets of small size; clock ports show up now and then.
   task automatic random_sets(int element_budget);
      int          size;
      logic [1:0]  kind;
      while (element_budget > 0) begin
         size = $urandom_range(1, 16);
         for (int i = 0; i < size; i++) begin
            kind = ($urandom_range(0, 9) == 0) ? fdsc_pkg::KIND_CLOCK
                                               : 2'($urandom_range(0, 2));
            send_element(kind, draw_fanout(), 16'($urandom_range(0, 65535)),
                         i == size - 1);
         end
         element_budget -= size;
         if ($urandom_range(0, 3) == 0) gaps_off = !gaps_off;
      end
      gaps_off = 1'b0;
   endtask

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_element_kind    = fdsc_pkg::KIND_COMB;
      req_fanout_degree   = '0;
      req_fanin_degree    = '0;
      req_last_element    = 1'b0;
      csr_valid           = 1'b0;
      csr_fixed_threshold = '0;
      cycle_count         = 0;
      elements_sent       = 0;
      sets_sent           = 0;
      gaps_off            = 1'b0;
      sink_hold           = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: every kind, extremes, clock ports ignored, empty kinds.
      send_element(fdsc_pkg::KIND_COMB, 16'd0, 16'd0, 1'b0);
      send_element(fdsc_pkg::KIND_SEQ, 16'hFFFF, 16'hFFFF, 1'b0);
      send_element(fdsc_pkg::KIND_PI, 16'd10, 16'h5555, 1'b0);
      send_element(fdsc_pkg::KIND_CLOCK, 16'd7, 16'hAAAA, 1'b0);
      send_element(fdsc_pkg::KIND_COMB, 16'd9, 16'd3, 1'b1);
      send_element(fdsc_pkg::KIND_CLOCK, 16'hFFFF, 16'hFFFF, 1'b1); // set with no elements
      send_element(fdsc_pkg::KIND_SEQ, 16'd5, 16'd1, 1'b1);          // one kind only
      send_element(fdsc_pkg::KIND_COMB, 16'hFFFF, 16'hFFFF, 1'b0);
      send_element(fdsc_pkg::KIND_COMB, 16'hFFFF, 16'hFFFF, 1'b0);
      send_element(fdsc_pkg::KIND_PI, 16'd0, 16'd0, 1'b0);
      send_element(fdsc_pkg::KIND_CLOCK, 16'd3, 16'd0, 1'b1);        // clock port closes set
      send_element(fdsc_pkg::KIND_PI, 16'h00FF, 16'hFF00, 1'b0);
      send_element(fdsc_pkg::KIND_SEQ, 16'hFF00, 16'h00FF, 1'b1);

      write_threshold(16'd0);
      random_sets(150);
      write_threshold(16'hFFFF);
      random_sets(150);

      // Hold the sink off while sets keep coming so the core backs up.
      write_threshold(16'($urandom_range(1, 40)));
      sink_hold = 3000;
      random_sets(150);
      req_valid <= 1'b0;

      @(posedge clock);
      while (stats_pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Covered %0d elements in %0d data sets, %0d statistics checked.",
               elements_sent, sets_sent, stats_seen);
      $display("Thresholds 0, max and random; empty and clock-only sets; long sink stall.");
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
